// ----- rtl/fastbus_adc_bank_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the crate bank decoder
// Shared concurrent assertion forms, all clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FASTBUS_ADC_BANK_DECODER_DEFINES_SVH
`define FASTBUS_ADC_BANK_DECODER_DEFINES_SVH

// Condition must never hold.
`define FBADC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FBADC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FBADC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fbadc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbadc_pkg
// Types, register indexes and constants shared by the crate bank decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbadc_pkg;

  // Crate header compare mask
  localparam logic [31:0] HDR_MASK = 32'hff0f_ff00;

  // Default depth of the queue between front and back
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER_PATTERN = 2'd0;
  localparam logic [1:0] CFG_ALIGNMENT_WORD = 2'd1;
  localparam logic [1:0] CFG_END_WORD       = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HIT           = 2'd0,
    KIND_BAD_HEADER    = 2'd1,
    KIND_SLOT_MISMATCH = 2'd2
  } kind_t;

  // One readout word
  typedef struct packed {
    logic [31:0] data_word;
    logic        first_word;
  } in_item_t;

  // One decoded result
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  crate_number;
    logic [4:0]  board_slot;
    logic [4:0]  word_slot;
    logic [5:0]  adc_channel;
    logic [13:0] adc_sample;
    logic [31:0] raw_word;
  } out_item_t;

  // Classified word waiting for formatting
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  crate;
    logic [4:0]  slot;
    logic [31:0] word;
  } entry_t;

  // Queue write request from the front
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/fbadc_front.sv -----
// ----------------------------------------------------------------------------
// fbadc_front
// Accepts readout words, tracks bank/board position and classifies each
// data word; pushes every word that makes a result into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fastbus_adc_bank_decoder_defines.svh"

module fbadc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration writes
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // word input
  input  wire logic               item_valid,
  input  wire fbadc_pkg::in_item_t item,
  output      logic               item_ready,
  // queue side
  input  wire logic               q_full,
  output fbadc_pkg::push_t        push
);

  typedef enum logic [3:0] {
    PH_IDLE          = 4'b0001,
    PH_BOARD         = 4'b0010,
    PH_BOARD_NOALIGN = 4'b0100,
    PH_DATA          = 4'b1000
  } phase_t;

  logic [31:0] header_pattern;
  logic [31:0] alignment_word;
  logic [31:0] end_word;

  phase_t      phase, phase_next;
  logic [7:0]  boards_left, boards_left_next;
  logic [3:0]  crate_reg, crate_reg_next;
  logic [4:0]  slot_reg, slot_reg_next;
  logic [6:0]  words_left, words_left_next;

  logic        accept;
  logic [31:0] w;
  logic [6:0]  hdr_cnt;
  logic [7:0]  boards_dec;
  logic [6:0]  words_dec;
  phase_t      fin_phase;
  logic        hdr_match;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= '0;
      alignment_word <= '0;
      end_word       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbadc_pkg::CFG_HEADER_PATTERN: header_pattern <= cfg_data;
        fbadc_pkg::CFG_ALIGNMENT_WORD: alignment_word <= cfg_data;
        fbadc_pkg::CFG_END_WORD:       end_word       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign w          = item.data_word;
  assign hdr_cnt    = w[6:0];
  assign boards_dec = boards_left - 8'd1;
  assign words_dec  = words_left - 7'd1;
  assign fin_phase  = (boards_dec == 8'd0) ? PH_IDLE : PH_BOARD;
  assign hdr_match  = ((w & fbadc_pkg::HDR_MASK) == header_pattern);

  // bank walker and classifier
  always_comb begin
    phase_next       = phase;
    boards_left_next = boards_left;
    crate_reg_next   = crate_reg;
    slot_reg_next    = slot_reg;
    words_left_next  = words_left;
    push.valid       = 1'b0;
    push.entry.kind  = fbadc_pkg::KIND_HIT;
    push.entry.crate = crate_reg;
    push.entry.slot  = slot_reg;
    push.entry.word  = w;
    if (accept) begin
      if (item.first_word) begin
        if (!hdr_match) begin
          phase_next       = PH_IDLE;
          boards_left_next = 8'd0;
          push.valid       = 1'b1;
          push.entry.kind  = fbadc_pkg::KIND_BAD_HEADER;
        end else begin
          crate_reg_next   = w[23:20];
          boards_left_next = w[7:0];
          words_left_next  = 7'd0;
          phase_next       = (w[7:0] == 8'd0) ? PH_IDLE : PH_BOARD;
        end
      end else begin
        case (phase)
          PH_BOARD, PH_BOARD_NOALIGN: begin
            if (phase == PH_BOARD && w == alignment_word) begin
              phase_next = PH_BOARD_NOALIGN;
            end else if (phase == PH_BOARD && w == end_word) begin
              phase_next       = PH_IDLE;
              boards_left_next = 8'd0;
            end else begin
              // board header
              slot_reg_next = w[31:27];
              if (hdr_cnt <= 7'd1) begin
                words_left_next  = 7'd0;
                boards_left_next = boards_dec;
                phase_next       = fin_phase;
              end else begin
                words_left_next = hdr_cnt - 7'd1;
                phase_next      = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            push.valid      = 1'b1;
            push.entry.kind = (w[31:27] == slot_reg) ? fbadc_pkg::KIND_HIT
                                                     : fbadc_pkg::KIND_SLOT_MISMATCH;
            words_left_next = words_dec;
            if (words_dec == 7'd0) begin
              boards_left_next = boards_dec;
              phase_next       = fin_phase;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      boards_left <= '0;
      crate_reg   <= '0;
      slot_reg    <= '0;
      words_left  <= '0;
    end else begin
      phase       <= phase_next;
      boards_left <= boards_left_next;
      crate_reg   <= crate_reg_next;
      slot_reg    <= slot_reg_next;
      words_left  <= words_left_next;
    end
  end

  `FBADC_ASSERT_IMPL(a_data_has_words, clk, rst, phase == PH_DATA, words_left != 7'd0,
                     "data phase with no words left")
  `FBADC_ASSERT_IMPL(a_board_has_boards, clk, rst,
                     phase == PH_BOARD || phase == PH_BOARD_NOALIGN, boards_left != 8'd0,
                     "board phase with no boards left")

endmodule

`default_nettype wire

// ----- rtl/fbadc_queue.sv -----
// ----------------------------------------------------------------------------
// fbadc_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fastbus_adc_bank_decoder_defines.svh"

module fbadc_queue #(
  parameter int unsigned DEPTH = fbadc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fbadc_pkg::push_t push,
  output      logic             full,
  input  wire logic             pop,
  output      logic             q_valid,
  output fbadc_pkg::entry_t     q_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fbadc_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FBADC_ASSERT_NEVER(a_no_overflow, clk, rst, push.valid && full, "push into full queue")
  `FBADC_ASSERT_NEVER(a_count_range, clk, rst, count > CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ----- rtl/fbadc_back.sv -----
// ----------------------------------------------------------------------------
// fbadc_back
// Takes classified words from the queue, extracts the result fields and
// holds them in the output register until transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbadc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire fbadc_pkg::entry_t q_entry,
  output      logic              pop,
  output      logic              result_valid,
  input  wire logic              result_ready,
  output fbadc_pkg::out_item_t   result
);

  fbadc_pkg::out_item_t fmt;

  // load the output register when it is empty or being drained
  assign pop = q_valid && (!result_valid || result_ready);

  // field extraction per kind
  always_comb begin
    fmt = '0;
    case (q_entry.kind)
      fbadc_pkg::KIND_HIT: begin
        fmt.result_kind  = fbadc_pkg::KIND_HIT;
        fmt.crate_number = q_entry.crate;
        fmt.board_slot   = q_entry.slot;
        fmt.word_slot    = q_entry.word[31:27];
        fmt.adc_channel  = q_entry.word[22:17];
        fmt.adc_sample   = q_entry.word[13:0];
      end
      fbadc_pkg::KIND_SLOT_MISMATCH: begin
        fmt.result_kind  = fbadc_pkg::KIND_SLOT_MISMATCH;
        fmt.crate_number = q_entry.crate;
        fmt.board_slot   = q_entry.slot;
        fmt.word_slot    = q_entry.word[31:27];
        fmt.raw_word     = q_entry.word;
      end
      default: begin
        // bad crate header: only the word itself is reported
        fmt.result_kind = fbadc_pkg::KIND_BAD_HEADER;
        fmt.raw_word    = q_entry.word;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= fmt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fastbus_adc_bank_decoder.sv -----
// ----------------------------------------------------------------------------
// fastbus_adc_bank_decoder
// Crate bank decoder for Fastbus ADC readout words: one word in, at most one
// hit or error result out.
// ----------------------------------------------------------------------------
// The block takes one readout word per clock cycle and keeps that rate as long
// as results are taken; the bank walker in the front updates its position
// state in the same cycle a word transfers. A word that makes a result is
// written into the queue at its own transfer edge and loaded into the output
// register once that register is empty or being drained, so its result is
// offered on the result port from the output register. Between front and back sits a queue of
// QUEUE_DEPTH entries; item_ready drops only while that queue is full.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// made while no bank words are in flight.
`timescale 1ns / 1ps
`default_nettype none

module fastbus_adc_bank_decoder #(
  parameter int unsigned QUEUE_DEPTH = fbadc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  // readout words
  input  wire logic                item_valid,
  output      logic                item_ready,
  input  wire fbadc_pkg::in_item_t item,
  // results
  output      logic                result_valid,
  input  wire logic                result_ready,
  output fbadc_pkg::out_item_t     result
);

  fbadc_pkg::push_t  push;
  fbadc_pkg::entry_t q_entry;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  fbadc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .q_full     (q_full),
    .push       (push)
  );

  fbadc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  fbadc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- test/bank_decode_check.sv -----
// ----------------------------------------------------------------------------
// Crate bank decode checker
// Watches the configuration, readout word and result channels of the crate
// bank decoder. Keeps its own copy of the bank walker and the registers,
// works out the result of every readout word transfer and compares each
// result transfer, field by field, with the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bank_decode_check (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 item_valid,
  input  wire logic                 item_ready,
  input  fbadc_pkg::in_item_t       item,
  input  wire logic                 result_valid,
  input  wire logic                 result_ready,
  input  fbadc_pkg::out_item_t      result,
  output int                        mismatch_count,
  output int                        results_due
);

  // Position of the walker inside a bank
  typedef enum logic [1:0] {
    WAIT_HEADER       = 2'd0,
    WAIT_BOARD        = 2'd1,
    BOARD_AFTER_ALIGN = 2'd2,
    READ_DATA         = 2'd3
  } walk_t;

  logic [31:0] hdr_pattern;
  logic [31:0] align_word;
  logic [31:0] end_marker;

  walk_t       walk;
  logic [7:0]  boards_left;
  logic [3:0]  crate_num;
  logic [4:0]  board_slot;
  logic [6:0]  words_left;

  fbadc_pkg::out_item_t expected_results[$];
  int                   mismatches;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    mismatches     = 0;
  end

  // One board done: on to the next one or back to idle
  task automatic close_board();
    boards_left = boards_left - 8'd1;
    walk = (boards_left == 8'd0) ? WAIT_HEADER : WAIT_BOARD;
  endtask

  // Board header: slot and data word count
  task automatic take_board(logic [31:0] w);
    board_slot = w[31:27];
    if (w[6:0] <= 7'd1) begin
      words_left = 7'd0;
      close_board();
    end else begin
      words_left = w[6:0] - 7'd1;
      walk = READ_DATA;
    end
  endtask

  // Walk one readout word, queue the result it makes, if any
  task automatic decode_word(fbadc_pkg::in_item_t it);
    fbadc_pkg::out_item_t r;
    logic [31:0]          w;
    logic [4:0]           ws;
    r = '0;
    w = it.data_word;
    if (it.first_word) begin
      if ((w & fbadc_pkg::HDR_MASK) != hdr_pattern) begin
        walk          = WAIT_HEADER;
        boards_left   = 8'd0;
        r.result_kind = fbadc_pkg::KIND_BAD_HEADER;
        r.raw_word    = w;
        expected_results.insert(expected_results.size(), r);
      end else begin
        crate_num   = w[23:20];
        boards_left = w[7:0];
        words_left  = 7'd0;
        walk = (boards_left == 8'd0) ? WAIT_HEADER : WAIT_BOARD;
      end
    end else begin
      case (walk)
        WAIT_BOARD: begin
          if (w == align_word) begin
            walk = BOARD_AFTER_ALIGN;
          end else if (w == end_marker) begin
            walk        = WAIT_HEADER;
            boards_left = 8'd0;
          end else begin
            take_board(w);
          end
        end
        // any word after an alignment word is a board header
        BOARD_AFTER_ALIGN: begin
          take_board(w);
        end
        READ_DATA: begin
          ws             = w[31:27];
          r.crate_number = crate_num;
          r.board_slot   = board_slot;
          r.word_slot    = ws;
          if (ws == board_slot) begin
            r.result_kind = fbadc_pkg::KIND_HIT;
            r.adc_channel = w[22:17];
            r.adc_sample  = w[13:0];
          end else begin
            r.result_kind = fbadc_pkg::KIND_SLOT_MISMATCH;
            r.raw_word    = w;
          end
          expected_results.insert(expected_results.size(), r);
          words_left = words_left - 7'd1;
          if (words_left == 7'd0) close_board();
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    fbadc_pkg::out_item_t want;
    logic                 bad;
    if (rst) begin
      hdr_pattern = '0;
      align_word  = '0;
      end_marker  = '0;
      walk        = WAIT_HEADER;
      boards_left = '0;
      crate_num   = '0;
      board_slot  = '0;
      words_left  = '0;
      expected_results.delete();
    end else begin
      // result transfer: compare with the oldest expectation
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %p", $realtime, result);
        end else begin
          want = expected_results.pop_front();
          bad = (want.result_kind  !== result.result_kind)  ||
                (want.crate_number !== result.crate_number) ||
                (want.board_slot   !== result.board_slot)   ||
                (want.word_slot    !== result.word_slot)    ||
                (want.adc_channel  !== result.adc_channel)  ||
                (want.adc_sample   !== result.adc_sample)   ||
                (want.raw_word     !== result.raw_word);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch, expected %p", $realtime, want);
              $display("%0t: result mismatch, actual   %p", $realtime, result);
            end
          end
        end
      end
      // register write; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbadc_pkg::CFG_HEADER_PATTERN: hdr_pattern = cfg_data;
          fbadc_pkg::CFG_ALIGNMENT_WORD: align_word  = cfg_data;
          fbadc_pkg::CFG_END_WORD:       end_marker  = cfg_data;
          default: begin
          end
        endcase
      end
      if (item_valid && item_ready) decode_word(item);
    end
    results_due    <= expected_results.size();
    mismatch_count <= mismatches;
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Crate bank decoder testbench
// Drives readout word banks into the decoder: a directed set covering header
// errors, alignment and end words, empty boards and abandoned banks, then
// random banks under several register settings and idle patterns. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         SETTLE_CYCLES  = 8;
  // index with no register behind it
  localparam logic [1:0] CFG_SPARE      = 2'd3;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index    = '0;
  logic [31:0]          cfg_data     = '0;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  fbadc_pkg::in_item_t  item         = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  fbadc_pkg::out_item_t result;

  int mismatch_count;
  int results_due;
  int send_idle    = 0;
  int recv_idle    = 0;
  int words_sent   = 0;
  int quiet_cycles = 0;

  // current register values, used to shape the stimulus
  logic [31:0] cur_pattern = '0;
  logic [31:0] cur_align   = '0;
  logic [31:0] cur_end     = '0;

  fastbus_adc_bank_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  bank_decode_check decode_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #5 clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog on cycles without any transfer
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // One readout word transfer, with random idle cycles in front
  task automatic put_word(logic [31:0] w, logic f);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{w, f};
    do @(posedge clk); while (!item_ready);
    words_sent++;
  endtask

  // One register write transfer
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] p, logic [31:0] a, logic [31:0] e);
    cur_pattern = p;
    cur_align   = a;
    cur_end     = e;
    write_reg(fbadc_pkg::CFG_HEADER_PATTERN, p);
    write_reg(fbadc_pkg::CFG_ALIGNMENT_WORD, a);
    write_reg(fbadc_pkg::CFG_END_WORD, e);
    write_reg(CFG_SPARE, $urandom);
  endtask

  // Stop sending and wait until every result is in and the pipe is empty
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] crate_header_word(logic [3:0] crate, logic [7:0] boards);
    logic [31:0] w;
    w        = cur_pattern & fbadc_pkg::HDR_MASK;
    w[23:20] = crate;
    w[7:0]   = boards;
    return w;
  endfunction

  // One random bank, mostly well formed; some noise, bad headers, cut banks
  task automatic send_bank();
    int          pick;
    int          boards;
    int          cut;
    int          cnt;
    bit          aligned;
    logic [4:0]  slot;
    logic [31:0] w;
    pick = $urandom_range(99);
    if (pick < 8) begin
      put_word($urandom, 1'b0);
    end else if (pick < 16) begin
      w = $urandom;
      if ((w & fbadc_pkg::HDR_MASK) == cur_pattern) w[8] = ~w[8];
      put_word(w, 1'b1);
    end else begin
      pick = $urandom_range(99);
      if (pick < 5)       boards = 0;
      else if (pick < 12) boards = $urandom_range(5, 255);
      else                boards = $urandom_range(1, 4);
      // long banks are cut short by the next bank header
      cut = (boards > 4) ? $urandom_range(1, 3) : boards;
      put_word(crate_header_word(4'($urandom), 8'(boards)), 1'b1);
      for (int b = 0; b < cut; b++) begin
        aligned = ($urandom_range(99) < 20);
        if (aligned) put_word(cur_align, 1'b0);
        if (!aligned && $urandom_range(99) < 5) begin
          put_word(cur_end, 1'b0);
          return;
        end
        if (aligned && $urandom_range(99) < 25) begin
          w = $urandom_range(1) ? cur_align : cur_end;
        end else begin
          pick = $urandom_range(99);
          if (pick < 70)      cnt = $urandom_range(0, 6);
          else if (pick < 95) cnt = $urandom_range(7, 20);
          else                cnt = $urandom_range(21, 127);
          slot = 5'($urandom);
          do begin
            w        = $urandom;
            w[31:27] = slot;
            w[6:0]   = 7'(cnt);
          end while (!aligned && (w == cur_align || w == cur_end));
        end
        put_word(w, 1'b0);
        slot = w[31:27];
        cnt  = w[6:0];
        for (int d = 1; d < cnt; d++) begin
          if ($urandom_range(99) < 2) return;
          w = $urandom;
          if ($urandom_range(99) < 85) w[31:27] = slot;
          put_word(w, 1'b0);
        end
      end
      // trailing words after the bank are ignored
      if ($urandom_range(99) < 20) put_word($urandom, 1'b0);
    end
  endtask

  task automatic run_words(int n);
    int stop;
    stop = words_sent + n;
    while (words_sent < stop) send_bank();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle = 25;
    recv_idle = 62;

    // directed banks
    set_regs(32'h5A0C_3A00, 32'hA000_0001, 32'hE5E5_E500);
    put_word(32'h1234_5678, 1'b0);          // outside a bank: ignored
    put_word(32'h0000_0000, 1'b1);          // bad header
    put_word(32'hFFFF_FFFF, 1'b1);          // bad header
    put_word(crate_header_word(4'hF, 8'd4), 1'b1);
    put_word(cur_align, 1'b0);
    put_word(cur_align, 1'b0);              // alignment word as board header
    put_word(32'hF800_0003, 1'b0);          // slot 31, two data words
    put_word(32'hF87E_3FFF, 1'b0);          // hit, top channel and value
    put_word(32'h07FF_FFFF, 1'b0);          // slot mismatch
    put_word(cur_align, 1'b0);
    put_word(cur_end, 1'b0);                // end word as board header
    put_word(cur_end, 1'b0);                // closes the bank
    put_word(32'h0000_0001, 1'b0);          // ignored
    put_word(crate_header_word(4'h0, 8'd0), 1'b1); // no boards
    put_word(32'hF800_0005, 1'b0);          // ignored
    put_word(crate_header_word(4'h7, 8'd2), 1'b1);
    put_word(32'h0000_0000, 1'b0);          // board with count 0
    put_word(32'h0000_0002, 1'b0);
    put_word(32'h0000_0000, 1'b0);          // hit, all zero fields
    put_word(crate_header_word(4'h3, 8'd255), 1'b1);
    put_word(32'h4800_007F, 1'b0);          // slot 9, largest count
    put_word(32'h4801_2345, 1'b0);
    put_word(crate_header_word(4'h9, 8'd1), 1'b1); // abandons the open board
    put_word(32'h0800_0001, 1'b0);
    settle();

    // random banks under three idle patterns and several register settings
    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 25 : (m == 1) ? 62 : 0;
      recv_idle = (m == 0) ? 62 : (m == 1) ? 25 : 0;
      set_regs($urandom & fbadc_pkg::HDR_MASK, $urandom, $urandom);
      run_words(140);
      settle();
      case (m)
        0:       set_regs('0, '0, '0);
        1:       set_regs('1, '1, '1);     // no header can match
        default: set_regs(fbadc_pkg::HDR_MASK, $urandom, $urandom);
      endcase
      run_words((m == 1) ? 20 : 40);
      settle();
    end

    if (mismatch_count == 0 && results_due == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
